>>> src/mlxf_pkg.sv
// Shared constants and controller/datapath interface types for the frame receiver.
`timescale 1ns / 1ps

package mlxf_pkg;

    localparam int MAX_PAYLOAD = 28;
    localparam int STORE_ADDR_W = $clog2(MAX_PAYLOAD);

    localparam int BYTE_W = 8;
    localparam int POS_W = 6;
    localparam int KIND_W = 2;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] CHECK_MASK = 8'h7F;

    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BAD_CHECK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOO_LONG = 2'd2;

    typedef struct packed {
        logic              sync_clear;
        logic              load_cmd;
        logic              load_len;
        logic              store_byte;
        logic              set_result;
        logic [KIND_W-1:0] result_kind;
        logic              start_read;
        logic              next_read;
        logic              load_elem;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_sync;
        logic len_zero;
        logic len_big;
        logic more;
        logic check_ok;
        logic pos_zero;
        logic out_last;
    } dp_status_t;

endpackage

>>> src/magic_length_xor_frame_receiver.sv
// Top level of the sync-byte framed receiver with 7-bit XOR check.
//
// Bytes enter on the s_ stream one request at a time. A byte equal to the
// sync register starts a frame anywhere; then come command, length L, L-1
// payload bytes (up to the store depth) and a check byte equal to the payload
// XOR masked to 7 bits. Bytes are taken back to back while parsing; a byte
// that completes a frame blocks the input until all its results have been taken.
// A good frame leaves the m_ stream as one request per payload byte, tlast on
// the final one; an empty frame, a check mismatch (tuser 1) or a length beyond
// the store (tuser 2) leave as one request with tlast set.
// A single result is shown in the cycle after the completing byte; for payload
// runs each element is read from the store in a load state and then loaded into
// the output register before it is shown, and each request holds until m_tready.
// While a result waits on m_tready, the output request holds and s_tready stays low.
// Reset clears the parser to wait for sync and sets the sync value to 0xAA;
// cfg_wr_en loads a new sync value while the block is idle; the user is bound to this, the block does not enforce it.
`timescale 1ns / 1ps

module magic_length_xor_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,  // sync_value
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // command, frame_len, index, payload_byte, zero pad
    output logic [1:0]  m_tuser,      // kind
    output logic        m_tlast
);

    import mlxf_pkg::*;

    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] frame_len;
    logic [POS_W-1:0]  index;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;

    mlxf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rx_valid (s_tvalid),
        .rx_ready (s_tready),
        .res_valid(m_tvalid),
        .res_ready(m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mlxf_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_byte     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .kind        (kind),
        .command     (command),
        .frame_len   (frame_len),
        .index       (index),
        .payload_byte(payload_byte),
        .last        (last)
    );

    assign m_tdata = {2'b00, payload_byte, index, frame_len, command};
    assign m_tuser = kind;
    assign m_tlast = last;

endmodule

>>> src/mlxf_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module mlxf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 28
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/mlxf_datapath.sv
// Frame datapath: header registers, running check, payload store and output register.
`timescale 1ns / 1ps

module mlxf_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [mlxf_pkg::BYTE_W-1:0] cfg_wr_data,
    input  logic [mlxf_pkg::BYTE_W-1:0] rx_byte,
    input  mlxf_pkg::ctrl_cmd_t        cmd,
    output mlxf_pkg::dp_status_t       status,
    output logic [mlxf_pkg::KIND_W-1:0] kind,
    output logic [mlxf_pkg::BYTE_W-1:0] command,
    output logic [mlxf_pkg::BYTE_W-1:0] frame_len,
    output logic [mlxf_pkg::POS_W-1:0]  index,
    output logic [mlxf_pkg::BYTE_W-1:0] payload_byte,
    output logic                       last
);

    import mlxf_pkg::*;

    logic [BYTE_W-1:0] sync_reg;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [POS_W-1:0]  index_reg, index_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;
    logic [BYTE_W-1:0] ram_rd_data;
    logic              rd_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg <= SYNC_RESET;
        end else if (cfg_wr_en) begin
            sync_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg    <= '0;
            len_reg    <= '0;
            xor_reg    <= '0;
            pos_reg    <= '0;
            rd_idx_reg <= '0;
        end else begin
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            xor_reg    <= xor_next;
            pos_reg    <= pos_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        index_reg <= index_next;
        data_reg  <= data_next;
        last_reg  <= last_next;
    end

    assign rd_last = (rd_idx_reg + POS_W'(1)) == pos_reg;

    always_comb begin
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        xor_next    = xor_reg;
        pos_next    = pos_reg;
        rd_idx_next = rd_idx_reg;
        kind_next   = kind_reg;
        index_next  = index_reg;
        data_next   = data_reg;
        last_next   = last_reg;

        if (cmd.sync_clear || cmd.load_len) begin
            pos_next = '0;
            xor_next = '0;
        end
        if (cmd.load_cmd) begin
            cmd_next = rx_byte;
        end
        if (cmd.load_len) begin
            len_next = rx_byte;
        end
        if (cmd.store_byte) begin
            xor_next = xor_reg ^ rx_byte;
            pos_next = pos_reg + POS_W'(1);
        end
        if (cmd.start_read) begin
            rd_idx_next = '0;
        end else if (cmd.next_read) begin
            rd_idx_next = rd_idx_reg + POS_W'(1);
        end
        if (cmd.set_result) begin
            kind_next  = cmd.result_kind;
            index_next = '0;
            data_next  = '0;
            last_next  = 1'b1;
        end else if (cmd.load_elem) begin
            kind_next  = KIND_FRAME;
            index_next = rd_idx_reg;
            data_next  = ram_rd_data;
            last_next  = rd_last;
        end
    end

    mlxf_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(MAX_PAYLOAD)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (cmd.store_byte),
        .wr_addr(pos_reg[STORE_ADDR_W-1:0]),
        .wr_data(rx_byte),
        .rd_addr(rd_idx_next[STORE_ADDR_W-1:0]),
        .rd_data(ram_rd_data)
    );

    always_comb begin
        status.is_sync  = rx_byte == sync_reg;
        status.len_zero = rx_byte == '0;
        status.len_big  = (rx_byte - BYTE_W'(1)) > BYTE_W'(MAX_PAYLOAD);
        status.more     = ({{(BYTE_W-POS_W){1'b0}}, pos_reg} < (len_reg - BYTE_W'(1)))
                          && (pos_reg < POS_W'(MAX_PAYLOAD));
        status.check_ok = rx_byte == (xor_reg & CHECK_MASK);
        status.pos_zero = pos_reg == '0;
        status.out_last = last_reg;
    end

    assign kind         = kind_reg;
    assign command      = cmd_reg;
    assign frame_len    = len_reg;
    assign index        = index_reg;
    assign payload_byte = data_reg;
    assign last         = last_reg;

endmodule

>>> src/mlxf_ctrl.sv
// Frame controller: parses sync, command, length, payload and check, then drains results.
`timescale 1ns / 1ps

module mlxf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rx_valid,
    output logic                 rx_ready,
    output logic                 res_valid,
    input  logic                 res_ready,
    input  mlxf_pkg::dp_status_t status,
    output mlxf_pkg::ctrl_cmd_t  cmd
);

    import mlxf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMD  = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_DATA = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;
    localparam logic [2:0] ST_SEND = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       rx_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign rx_ready  = (state_reg == ST_IDLE) || (state_reg == ST_CMD)
                       || (state_reg == ST_LEN) || (state_reg == ST_DATA);
    assign res_valid = state_reg == ST_SEND;
    assign rx_fire   = rx_valid && rx_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE, ST_CMD, ST_LEN, ST_DATA: begin
                if (rx_fire) begin
                    if (status.is_sync) begin
                        cmd.sync_clear = 1'b1;
                        state_next     = ST_CMD;
                    end else begin
                        unique case (state_reg)
                            ST_CMD: begin
                                cmd.load_cmd = 1'b1;
                                state_next   = ST_LEN;
                            end
                            ST_LEN: begin
                                cmd.load_len = 1'b1;
                                priority if (status.len_zero) begin
                                    cmd.set_result  = 1'b1;
                                    cmd.result_kind = KIND_FRAME;
                                    state_next      = ST_SEND;
                                end else if (status.len_big) begin
                                    cmd.set_result  = 1'b1;
                                    cmd.result_kind = KIND_TOO_LONG;
                                    state_next      = ST_SEND;
                                end else begin
                                    state_next = ST_DATA;
                                end
                            end
                            ST_DATA: begin
                                priority if (status.more) begin
                                    cmd.store_byte = 1'b1;
                                end else if (!status.check_ok) begin
                                    cmd.set_result  = 1'b1;
                                    cmd.result_kind = KIND_BAD_CHECK;
                                    state_next      = ST_SEND;
                                end else if (status.pos_zero) begin
                                    cmd.set_result  = 1'b1;
                                    cmd.result_kind = KIND_FRAME;
                                    state_next      = ST_SEND;
                                end else begin
                                    cmd.start_read = 1'b1;
                                    state_next     = ST_LOAD;
                                end
                            end
                            default: begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_LOAD: begin
                cmd.load_elem = 1'b1;
                state_next    = ST_SEND;
            end
            ST_SEND: begin
                if (res_ready) begin
                    if (status.out_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next_read = 1'b1;
                        state_next    = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
